// ===== rtl/rcp_pkg.sv =====
package rcp_pkg;

    localparam int LINE_CAPACITY = 128;
    localparam int CNT_W         = $clog2(LINE_CAPACITY);
    localparam int NUM_KEYS      = 6;
    localparam int WIN_LEN       = 10;
    localparam int WIN_W         = 8 * WIN_LEN;
    localparam int MAG_W         = 16;
    localparam int VAL_W         = 16;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // newest character in the low byte of the window
    localparam logic [WIN_W-1:0] KEY_PAT [NUM_KEYS] = '{
        "\"throttle\"",
        {48'd0, "\"ly\""},
        {56'd0, "\"v\""},
        {32'd0, "\"turn\""},
        {48'd0, "\"rx\""},
        {56'd0, "\"w\""}
    };
    localparam logic [WIN_W-1:0] KEY_MASK [NUM_KEYS] = '{
        {80{1'b1}},
        {48'd0, {32{1'b1}}},
        {56'd0, {24{1'b1}}},
        {32'd0, {48{1'b1}}},
        {48'd0, {32{1'b1}}},
        {56'd0, {24{1'b1}}}
    };

    localparam int REG_VALUE_MIN = 0;
    localparam int REG_VALUE_MAX = 1;

    typedef enum logic [6:0] {
        PH_SEARCH = 7'b0000001,
        PH_COLON  = 7'b0000010,
        PH_SPACE  = 7'b0000100,
        PH_SIGN   = 7'b0001000,
        PH_DIGITS = 7'b0010000,
        PH_DONE   = 7'b0100000,
        PH_FAIL   = 7'b1000000
    } t_phase;

    typedef struct packed {
        t_phase           phase;
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_key;

    localparam t_key KEY_IDLE = '{phase: PH_SEARCH, neg: 1'b0, mag: '0};

    typedef struct packed {
        logic             ok;
        logic             thr_neg;
        logic [MAG_W-1:0] thr_mag;
        logic             trn_neg;
        logic [MAG_W-1:0] trn_mag;
    } t_pick;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
               (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
    endfunction

    function automatic t_key key_next(input t_key cur, input logic hit, input logic [7:0] c);
        t_key             nk;
        logic             dig;
        logic [MAG_W+3:0] prod;
        nk   = cur;
        dig  = (c >= CH_ZERO) && (c <= CH_NINE);
        prod = ({4'd0, cur.mag} << 3) + ({4'd0, cur.mag} << 1) + {{MAG_W{1'b0}}, c[3:0]};
        case (cur.phase)
            PH_SEARCH: begin
                if (hit) nk.phase = PH_COLON;
            end
            PH_COLON: begin
                if (c == CH_COLON) nk.phase = PH_SPACE;
            end
            PH_SPACE: begin
                if (is_space(c)) begin
                    nk.phase = PH_SPACE;
                end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
                    nk.neg   = (c == CH_MINUS);
                    nk.phase = PH_SIGN;
                end else if (dig) begin
                    nk.mag   = {{(MAG_W-4){1'b0}}, c[3:0]};
                    nk.phase = PH_DIGITS;
                end else begin
                    nk.phase = PH_FAIL;
                end
            end
            PH_SIGN: begin
                if (dig) begin
                    nk.mag   = {{(MAG_W-4){1'b0}}, c[3:0]};
                    nk.phase = PH_DIGITS;
                end else begin
                    nk.phase = PH_FAIL;
                end
            end
            PH_DIGITS: begin
                if (dig) begin
                    nk.mag = (prod[MAG_W+3:MAG_W] != 4'd0) ? {MAG_W{1'b1}} : prod[MAG_W-1:0];
                end else begin
                    nk.phase = PH_DONE;
                end
            end
            default: begin
                nk = cur;
            end
        endcase
        return nk;
    endfunction

    function automatic logic key_ok(input t_key k);
        return (k.phase == PH_DIGITS) || (k.phase == PH_DONE);
    endfunction

endpackage

// ===== rtl/rcp_line_track.sv =====
module rcp_line_track (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  logic [7:0]    i_byte,
    output logic          o_fin,
    output rcp_pkg::t_pick o_pick
);
    import rcp_pkg::*;

    logic [CNT_W-1:0] r_cnt;
    logic             r_nul;
    logic [WIN_W-1:0] r_win;
    t_key             r_key [NUM_KEYS];

    logic             is_cr;
    logic             is_lf;
    logic             wrap;
    logic [CNT_W-1:0] b_cnt;
    logic             b_nul;
    logic [WIN_W-1:0] b_win;
    t_key             b_key [NUM_KEYS];
    logic             n_nul;
    logic [WIN_W-1:0] n_win;
    t_key             n_key [NUM_KEYS];
    t_key             view  [NUM_KEYS];
    logic [NUM_KEYS-1:0] hit;

    assign is_cr = (i_byte == CH_CR);
    assign is_lf = (i_byte == CH_LF);
    assign wrap  = (r_cnt >= CNT_W'(LINE_CAPACITY - 1));
    assign b_cnt = wrap ? '0 : r_cnt;
    assign b_nul = wrap ? 1'b0 : r_nul;
    assign b_win = wrap ? '0 : r_win;
    assign n_nul = b_nul | (i_byte == CH_NUL);
    assign n_win = n_nul ? b_win : {b_win[WIN_W-9:0], i_byte};
    assign o_fin = (is_lf && (r_cnt != '0)) || (i_byte == CH_RBRACE);

    always_comb begin
        for (int k = 0; k < NUM_KEYS; k++) begin
            b_key[k] = wrap ? KEY_IDLE : r_key[k];
            hit[k]   = ((n_win ^ KEY_PAT[k]) & KEY_MASK[k]) == '0;
            n_key[k] = n_nul ? b_key[k] : key_next(b_key[k], hit[k], i_byte);
            view[k]  = is_lf ? r_key[k] : n_key[k];
        end
    end

    always_comb begin
        o_pick = '0;
        if (key_ok(view[0])) begin
            o_pick.thr_neg = view[0].neg;
            o_pick.thr_mag = view[0].mag;
        end else if (key_ok(view[1])) begin
            o_pick.thr_neg = view[1].neg;
            o_pick.thr_mag = view[1].mag;
        end else begin
            o_pick.thr_neg = view[2].neg;
            o_pick.thr_mag = view[2].mag;
        end
        if (key_ok(view[3])) begin
            o_pick.trn_neg = view[3].neg;
            o_pick.trn_mag = view[3].mag;
        end else if (key_ok(view[4])) begin
            o_pick.trn_neg = view[4].neg;
            o_pick.trn_mag = view[4].mag;
        end else begin
            o_pick.trn_neg = view[5].neg;
            o_pick.trn_mag = view[5].mag;
        end
        o_pick.ok = (key_ok(view[0]) || key_ok(view[1]) || key_ok(view[2])) &&
                    (key_ok(view[3]) || key_ok(view[4]) || key_ok(view[5]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_nul <= 1'b0;
            r_win <= '0;
            for (int k = 0; k < NUM_KEYS; k++) r_key[k] <= KEY_IDLE;
        end else if (i_go && !is_cr) begin
            if (o_fin) begin
                r_cnt <= '0;
                r_nul <= 1'b0;
                r_win <= '0;
                for (int k = 0; k < NUM_KEYS; k++) r_key[k] <= KEY_IDLE;
            end else if (!is_lf) begin
                r_cnt <= b_cnt + 1'b1;
                r_nul <= n_nul;
                r_win <= n_win;
                for (int k = 0; k < NUM_KEYS; k++) r_key[k] <= n_key[k];
            end
        end
    end

endmodule

// ===== rtl/rc_command_line_parser.sv =====
// RC command line parser.
// s_axis carries one received character per request: tdata[7:0] is the byte,
// tdata[39:8] the millisecond time. CR is dropped; LF ends a non-empty line;
// a '}' is stored and ends the line. A line of LINE_CAPACITY-1 bytes restarts
// when one more byte is stored. Six key trackers and a ten-character window
// follow the line as it arrives.
// m_axis gives one request per finished line: tuser is the status (1 = parse
// error), tdata holds throttle, turn and the time of the ending byte.
// A finished line passes the input register, the tracker and pick register,
// then the clamp and output register, which holds the result while stalled.
// Throughput: one byte per cycle. A stalled receiver stops only a byte that
// ends a line while both the pick and output registers are full; other bytes
// keep flowing.
// value_min and value_max sit on the APB port at 0x0 and 0x4.
// Reset (synchronous, active low) empties the pipeline, clears the line and
// loads the limits with -1000 and 1000.
module rc_command_line_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // rx_byte[7:0], now_ms[39:8]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // throttle_value[15:0], turn_value[31:16], stamp_ms[63:32]
    output logic        m_axis_tuser,  // status[0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rcp_pkg::*;

    logic                    r_in_valid;
    logic [7:0]              r_in_byte;
    logic [31:0]             r_in_now;
    logic                    r_pk_valid;
    t_pick                   r_pk;
    logic [31:0]             r_pk_now;
    logic                    r_o_valid;
    logic                    r_o_status;
    logic [VAL_W-1:0]        r_o_thr;
    logic [VAL_W-1:0]        r_o_trn;
    logic [31:0]             r_o_now;
    logic signed [VAL_W-1:0] r_vmin;
    logic signed [VAL_W-1:0] r_vmax;

    logic             en_out;
    logic             pk_free;
    logic             in_fin;
    logic             in_go;
    t_pick            pick;
    logic [VAL_W-1:0] n_thr;
    logic [VAL_W-1:0] n_trn;
    logic             cfg_wr;

    function automatic logic [VAL_W-1:0] clamp(input logic neg, input logic [MAG_W-1:0] mag,
                                               input logic signed [VAL_W-1:0] lo,
                                               input logic signed [VAL_W-1:0] hi);
        logic signed [MAG_W:0] v;
        logic signed [MAG_W:0] lo_x;
        logic signed [MAG_W:0] hi_x;
        lo_x = {lo[VAL_W-1], lo};
        hi_x = {hi[VAL_W-1], hi};
        v    = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        if (v > hi_x) v = hi_x;
        if (v < lo_x) v = lo_x;
        return v[VAL_W-1:0];
    endfunction

    rcp_line_track u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (in_go),
        .i_byte  (r_in_byte),
        .o_fin   (in_fin),
        .o_pick  (pick)
    );

    assign en_out        = !r_o_valid || m_axis_tready;
    assign pk_free       = !r_pk_valid || en_out;
    assign in_go         = r_in_valid && (!in_fin || pk_free);
    assign s_axis_tready = !r_in_valid || in_go;

    assign n_thr = clamp(r_pk.thr_neg, r_pk.thr_mag, r_vmin, r_vmax);
    assign n_trn = clamp(r_pk.trn_neg, r_pk.trn_mag, r_vmin, r_vmax);

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tuser  = r_o_status;
    assign m_axis_tdata  = {r_o_now, r_o_trn, r_o_thr};

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == 1'(REG_VALUE_MAX)) ? {16'd0, r_vmax} : {16'd0, r_vmin};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vmin <= -16'sd1000;
            r_vmax <= 16'sd1000;
        end else if (cfg_wr) begin
            if (paddr[2] == 1'(REG_VALUE_MAX)) r_vmax <= pwdata[VAL_W-1:0];
            else                               r_vmin <= pwdata[VAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata[7:0];
            r_in_now  <= s_axis_tdata[39:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pk_valid <= 1'b0;
        end else if (pk_free) begin
            r_pk_valid <= in_go && in_fin;
        end
        if (pk_free && in_go && in_fin) begin
            r_pk     <= pick;
            r_pk_now <= r_in_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en_out) begin
            r_o_valid <= r_pk_valid;
        end
        if (en_out && r_pk_valid) begin
            r_o_status <= !r_pk.ok;
            r_o_thr    <= r_pk.ok ? n_thr : '0;
            r_o_trn    <= r_pk.ok ? n_trn : '0;
            r_o_now    <= r_pk_now;
        end
    end

endmodule

// ===== rtl/rcp_checker.sv =====
module rcp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result request present after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result request changed");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[31:0] == 32'd0)
        else $error("parse error with nonzero values");

    a_no_stall_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid && !s_axis_tready |=> s_axis_tready || m_axis_tvalid)
        else $error("input held with output idle");

endmodule

bind rc_command_line_parser rcp_checker u_rcp_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import rcp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 6;
    localparam int PHASE_BYTES = 20;

    typedef struct packed {
        logic        status;
        logic [15:0] throttle;
        logic [15:0] turn;
        logic [31:0] stamp;
    } t_cmd;

    typedef struct {
        int          pad;
        string       text;
        int          nul_at;
        logic [31:0] stamp;
        bit          typed;
        t_cmd        cmd;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    rc_command_line_parser i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #10 i_clk = ~i_clk;

    logic signed [15:0] lim_lo;
    logic signed [15:0] lim_hi;
    int unsigned        held;
    bit                 hidden;
    logic [7:0]         window [WIN_LEN];
    t_key               trk [NUM_KEYS];

    string key_text [NUM_KEYS] = '{"\"throttle\"", "\"ly\"", "\"v\"",
                                   "\"turn\"", "\"rx\"", "\"w\""};
    string thr_names [3]  = '{"throttle", "ly", "v"};
    string turn_names [3] = '{"turn", "rx", "w"};

    logic signed [15:0] lo_set [PHASES] = '{-16'sd1000, 16'sh8000, 16'sd0, 16'sd500,
                                           16'sd32767, -16'sd20000};
    logic signed [15:0] hi_set [PHASES] = '{16'sd1000, 16'sd32767, 16'sd0, -16'sd500,
                                           16'sh8000, 16'sd20000};

    t_cmd        due_cmds [$];
    t_row        plan [$];
    logic [7:0]  line_q [$];
    int          errors = 0;
    int          cycles = 0;
    bit          idle_en = 1'b1;
    bit          gaps_on;
    bit          typed_due;
    t_cmd        typed_cmd;
    logic [31:0] clock_ms;

    task automatic flag_error(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic void clear_line();
        held   = 0;
        hidden = 1'b0;
        foreach (window[i]) window[i] = '0;
        foreach (trk[k]) trk[k] = '{phase: PH_SEARCH, neg: 1'b0, mag: '0};
    endfunction

    function automatic bit key_seen(int k);
        int n;
        n = key_text[k].len();
        if (held < n) return 1'b0;
        for (int i = 0; i < n; i++) begin
            if (window[i] != key_text[k][n-1-i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void track_char(logic [7:0] c);
        bit          dig;
        int unsigned m;
        dig = (c >= CH_ZERO) && (c <= CH_NINE);
        for (int i = WIN_LEN - 1; i > 0; i--) window[i] = window[i-1];
        window[0] = c;
        for (int k = 0; k < NUM_KEYS; k++) begin
            case (trk[k].phase)
                PH_SEARCH: begin
                    if (key_seen(k)) trk[k].phase = PH_COLON;
                end
                PH_COLON: begin
                    if (c == CH_COLON) trk[k].phase = PH_SPACE;
                end
                PH_SPACE: begin
                    if (c inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR}) begin
                        trk[k].phase = PH_SPACE;
                    end else if (c == CH_PLUS || c == CH_MINUS) begin
                        trk[k].neg   = (c == CH_MINUS);
                        trk[k].phase = PH_SIGN;
                    end else if (dig) begin
                        trk[k].mag   = 16'(c - CH_ZERO);
                        trk[k].phase = PH_DIGITS;
                    end else begin
                        trk[k].phase = PH_FAIL;
                    end
                end
                PH_SIGN: begin
                    if (dig) begin
                        trk[k].mag   = 16'(c - CH_ZERO);
                        trk[k].phase = PH_DIGITS;
                    end else begin
                        trk[k].phase = PH_FAIL;
                    end
                end
                PH_DIGITS: begin
                    if (dig) begin
                        m = 32'(trk[k].mag) * 10 + 32'(c - CH_ZERO);
                        trk[k].mag = (m > 65535) ? 16'hFFFF : m[15:0];
                    end else begin
                        trk[k].phase = PH_DONE;
                    end
                end
                default: begin
                end
            endcase
        end
    endfunction

    function automatic int first_ok(int base);
        for (int k = base; k < base + 3; k++) begin
            if (trk[k].phase == PH_DIGITS || trk[k].phase == PH_DONE) return k;
        end
        return -1;
    endfunction

    function automatic logic [15:0] clamp_key(int k);
        int v;
        v = int'(trk[k].mag);
        if (trk[k].neg) v = -v;
        if (v > lim_hi) v = lim_hi;
        if (v < lim_lo) v = lim_lo;
        return v[15:0];
    endfunction

    function automatic t_cmd finish_line(logic [31:0] now);
        int   t;
        int   r;
        t_cmd res;
        t          = first_ok(0);
        r          = first_ok(3);
        res        = '0;
        res.status = 1'b1;
        res.stamp  = now;
        if (t >= 0 && r >= 0) begin
            res.status   = 1'b0;
            res.throttle = clamp_key(t);
            res.turn     = clamp_key(r);
        end
        clear_line();
        return res;
    endfunction

    function automatic bit predict_byte(logic [7:0] c, logic [31:0] now, output t_cmd res);
        res = '0;
        if (c == CH_CR) return 1'b0;
        if (c == CH_LF) begin
            if (held == 0) return 1'b0;
            res = finish_line(now);
            return 1'b1;
        end
        if (held >= LINE_CAPACITY - 1) clear_line();
        held++;
        if (c == CH_NUL) hidden = 1'b1;
        if (!hidden) track_char(c);
        if (c == CH_RBRACE) begin
            res = finish_line(now);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
    endfunction

    function automatic void put_blank();
        logic [7:0] pool [5];
        pool = '{CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR};
        repeat ($urandom_range(1, 3)) line_q.push_back(pool[$urandom_range(0, 4)]);
    endfunction

    function automatic string number_text();
        case ($urandom_range(0, 9))
            0: return "";
            1: return $sformatf("%0d", $urandom_range(0, 9));
            2: return $sformatf("%05d", $urandom_range(0, 999));
            3: return $sformatf("%0d", $urandom());
            4: begin
                case ($urandom_range(0, 3))
                    0: return "32767";
                    1: return "32768";
                    2: return "65535";
                    default: return "65536";
                endcase
            end
            5: return $sformatf("%0d", $urandom_range(0, 65535));
            default: return $sformatf("%0d", $urandom_range(0, 1500));
        endcase
    endfunction

    function automatic void put_field(string key, bit broken);
        int s;
        put_text({"\"", key, "\""});
        if ($urandom_range(0, 7) == 0) put_blank();
        if ($urandom_range(0, 11) != 0) line_q.push_back(CH_COLON);
        if ($urandom_range(0, 2) == 0) put_blank();
        s = $urandom_range(0, 3);
        if (s == 0) line_q.push_back(CH_PLUS);
        else if (s == 1) line_q.push_back(CH_MINUS);
        if ($urandom_range(0, 15) == 0) put_blank();
        if (broken) put_text("z");
        else put_text(number_text());
    endfunction

    function automatic void put_command();
        string tk;
        string rk;
        bit    drop_t;
        bit    drop_r;
        int    e;
        tk     = thr_names[$urandom_range(0, 2)];
        rk     = turn_names[$urandom_range(0, 2)];
        drop_t = ($urandom_range(0, 15) == 0);
        drop_r = ($urandom_range(0, 15) == 0);
        if ($urandom_range(0, 4) != 0) put_text("{");
        if ($urandom_range(0, 3) == 0) begin
            put_field($urandom_range(0, 1) ? thr_names[$urandom_range(0, 2)]
                                           : turn_names[$urandom_range(0, 2)], 1'b1);
            put_text(",");
        end
        if ($urandom_range(0, 1)) begin
            if (!drop_t) put_field(tk, 1'b0);
            put_text(",");
            if (!drop_r) put_field(rk, 1'b0);
        end else begin
            if (!drop_r) put_field(rk, 1'b0);
            put_text(",");
            if (!drop_t) put_field(tk, 1'b0);
        end
        if ($urandom_range(0, 4) == 0) begin
            put_text(",");
            put_field($urandom_range(0, 1) ? thr_names[$urandom_range(0, 2)]
                                           : turn_names[$urandom_range(0, 2)], 1'b0);
        end
        e = $urandom_range(0, 9);
        if (e < 7) begin
            put_text("}");
        end else if (e == 7) begin
            put_text("}");
            line_q.push_back(CH_CR);
            line_q.push_back(CH_LF);
        end else if (e == 8) begin
            line_q.push_back(CH_LF);
        end else begin
            line_q.push_back(CH_CR);
            line_q.push_back(CH_LF);
        end
        if ($urandom_range(0, 19) == 0)
            line_q.insert($urandom_range(0, line_q.size() - 1), CH_NUL);
    endfunction

    function automatic void put_random_line();
        int kind;
        kind = $urandom_range(0, 19);
        if (kind < 14) begin
            put_command();
        end else if (kind < 17) begin
            repeat ($urandom_range(1, 24)) line_q.push_back(8'($urandom_range(0, 255)));
            line_q.push_back(CH_LF);
        end else if (kind == 17) begin
            repeat ($urandom_range(100, 180)) line_q.push_back(8'($urandom_range(97, 122)));
            put_command();
        end else begin
            if ($urandom_range(0, 1)) line_q.push_back(CH_CR);
            line_q.push_back(CH_LF);
        end
    endfunction

    function automatic void add_row(int pad, string text, int nul_at, logic [31:0] stamp,
                                    bit typed, bit status, int thr, int trn);
        t_row r;
        r.pad          = pad;
        r.text         = text;
        r.nul_at       = nul_at;
        r.stamp        = stamp;
        r.typed        = typed;
        r.cmd.status   = status;
        r.cmd.throttle = 16'(thr);
        r.cmd.turn     = 16'(trn);
        r.cmd.stamp    = stamp;
        plan.push_back(r);
    endfunction

    function automatic void build_plan();
        add_row(0, "{\"throttle\":5,\"turn\":-7}", -1, 32'h0000_0000, 1, 0, 5, -7);
        add_row(0, "{\"ly\": 1000,\"rx\":-1000}\015\n", -1, 32'h0000_0001, 1, 0, 1000, -1000);
        add_row(0, "{\"v\":+12,\"w\":\t\v\f 34}", -1, 32'hFFFF_FFFF, 1, 0, 12, 34);
        add_row(0, "{\"throttle\":99999999,\"turn\":-99999999}", -1, 32'h8000_0000,
                1, 0, 1000, -1000);
        add_row(0, "{\"throttle\":x,\"ly\":7,\"turn\":3}", -1, 32'h7FFF_FFFF, 1, 0, 7, 3);
        add_row(0, "{\"v\":2,\"turn\":-,\"turn\":5,\"w\":6}", -1, 32'h0000_00FF, 1, 0, 2, 6);
        add_row(0, "{\"throttle\":5}", -1, 32'h1234_5678, 1, 1, 0, 0);
        add_row(0, "\n", -1, 32'h0000_0000, 0, 0, 0, 0);
        add_row(0, "{\"v\":3,\"w\":4}", 7, 32'hFFFF_0000, 1, 1, 0, 0);
        add_row(0, "{\"v\":\015-4\015,\"w\":5}\015\n", -1, 32'h0000_FFFF, 1, 0, -4, 5);
        add_row(0, "\"v\":1 \"w\":2\n", -1, 32'h5555_AAAA, 1, 0, 1, 2);
        add_row(0, "\377\200\"v\":0,\"w\":0}", -1, 32'hFFFF_FFFF, 1, 0, 0, 0);
        add_row(0, "{\"v\" :1,\"w\":2}", -1, 32'hAAAA_5555, 1, 0, 1, 2);
        add_row(0, "{\"v\":- 1,\"w\":2}", -1, 32'h0F0F_0F0F, 1, 1, 0, 0);
        add_row(0, "{\"v\":12a,\"w\":3}", -1, 32'hF0F0_F0F0, 1, 0, 12, 3);
        add_row(0, "\"throttle\":-1,\"turn\":+0}", -1, 32'h0000_0002, 1, 0, -1, 0);
        add_row(0, "hello\n", -1, 32'h0000_0003, 1, 1, 0, 0);
        add_row(0, "{\"w\":1,\"throttle\":32767,\"rx\":2}", -1, 32'h0000_0004, 0, 0, 0, 0);
        add_row(126, "}", -1, 32'h0000_0005, 0, 0, 0, 0);
        add_row(127, "}", -1, 32'h0000_0006, 0, 0, 0, 0);
        add_row(140, "{\"v\":9,\"w\":8}", -1, 32'h0000_0007, 0, 0, 0, 0);
    endfunction

    task automatic send_byte(logic [7:0] c, logic [31:0] now);
        t_cmd res;
        if (gaps_on && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {now, c};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (predict_byte(c, now, res)) begin
            if (typed_due) begin
                due_cmds.push_back(typed_cmd);
                typed_due = 1'b0;
            end else begin
                due_cmds.push_back(res);
            end
        end
    endtask

    task automatic send_line(bit fixed, logic [31:0] stamp);
        gaps_on = idle_en && ($urandom_range(0, 3) != 0);
        foreach (line_q[i]) begin
            if (!fixed) begin
                clock_ms += $urandom_range(0, 40);
                if ($urandom_range(0, 63) == 0) clock_ms = $urandom();
            end
            send_byte(line_q[i], fixed ? stamp : clock_ms);
        end
        line_q.delete();
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (due_cmds.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(int idx, logic signed [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * idx);
        pwdata  <= {{16{val[15]}}, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_VALUE_MIN) lim_lo = val;
        else lim_hi = val;
        @(posedge i_clk);
    endtask

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin : result_check
        int   stall;
        bit   calm;
        t_cmd got;
        t_cmd want;
        stall = 0;
        calm  = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16],
                       m_axis_tdata[63:32]};
                if (due_cmds.size() == 0) begin
                    flag_error($sformatf("command with none pending, status %0b", got.status));
                end else begin
                    want = due_cmds.pop_front();
                    if (got.status != want.status)
                        flag_error($sformatf("status got %0b want %0b",
                                             got.status, want.status));
                    if (got.throttle != want.throttle)
                        flag_error($sformatf("throttle got %0d want %0d",
                                             $signed(got.throttle), $signed(want.throttle)));
                    if (got.turn != want.turn)
                        flag_error($sformatf("turn got %0d want %0d",
                                             $signed(got.turn), $signed(want.turn)));
                    if (got.stamp != want.stamp)
                        flag_error($sformatf("stamp got %0h want %0h", got.stamp, want.stamp));
                end
            end
            if ($urandom_range(0, 63) == 0) calm = ~calm;
            if (stall > 0) stall--;
            else if (idle_en && !calm && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 16);
            m_axis_tready <= (stall == 0);
        end
    end

    initial begin : stimulus
        t_row r;
        int   sent;
        lim_lo   = -16'sd1000;
        lim_hi   = 16'sd1000;
        clock_ms = $urandom();
        clear_line();
        build_plan();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            r = plan[i];
            for (int j = 0; j < r.pad; j++) line_q.push_back(8'("a") + 8'(j % 26));
            for (int j = 0; j < r.text.len(); j++) begin
                if (j == r.nul_at) line_q.push_back(CH_NUL);
                line_q.push_back(r.text[j]);
            end
            typed_due = r.typed;
            typed_cmd = r.cmd;
            send_line(1'b1, r.stamp);
        end
        drain();

        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                write_reg(REG_VALUE_MIN, lo_set[p]);
                write_reg(REG_VALUE_MAX, hi_set[p]);
            end
            idle_en = (p < PHASES - 1);
            sent    = 0;
            while (sent < PHASE_BYTES) begin
                put_random_line();
                sent += line_q.size();
                send_line(1'b0, '0);
            end
            drain();
        end

        if (errors == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

endmodule
